// ----- rtl/core/log_ratio_event_trigger_core_assert.svh -----
// Assertion shorthands for the event trigger checker.
`ifndef LOG_RATIO_EVENT_TRIGGER_CORE_ASSERT_SVH
`define LOG_RATIO_EVENT_TRIGGER_CORE_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define LRET_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("event trigger check failed");

// Clocked property that also holds through reset.
`define LRET_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("event trigger check failed during reset");

`endif

// ----- rtl/core/lret_pkg.sv -----
package lret_pkg;

  localparam int TICK_BITS    = 31;
  localparam int TICK_COUNT_W = 31;
  localparam int SPACING_W    = 16;
  localparam int TCMP_W       = (TICK_BITS > SPACING_W) ? TICK_BITS : SPACING_W;

  localparam int SAMPLE_W = 16;
  localparam int AERR_W   = 15;
  localparam int PERR_W   = 17;
  localparam int ADB_W    = 15;
  localparam int PDB_W    = 16;
  localparam int BASE_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = BASE_W + PERR_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W:0]   PI_LSB           = 17'd16384;
  localparam logic [AERR_W-1:0]   ANGLE_ERR_MAX    = 15'h7fff;
  localparam logic [AERR_W-1:0]   ANGLE_REF_RESET  = 15'd1;
  localparam logic [PERR_W-1:0]   POS_REF_RESET    = 17'd3;
  localparam logic [BASE_W-1:0]   RATIO_BASE_RESET = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TICK_SPACING   = 4'd0,
    CFG_ANGLE_DEAD_BAND    = 4'd1,
    CFG_POSITION_DEAD_BAND = 4'd2,
    CFG_RATIO_BASE         = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SPACING_W-1:0] min_tick_spacing;
    logic [ADB_W-1:0]     angle_dead_band;
    logic [PDB_W-1:0]     position_dead_band;
    logic [BASE_W-1:0]    ratio_base;
  } cfg_t;

endpackage

// ----- rtl/core/lret_ifs.sv -----
interface lret_sample_if import lret_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] position;
  logic signed [SAMPLE_W-1:0] angle;
  logic signed [SAMPLE_W-1:0] target_position;
  logic                       target_down;
  logic                       tick_valid;
  logic [TICK_COUNT_W-1:0]    tick_count;

  modport source (output valid, position, angle, target_position, target_down,
                  tick_valid, tick_count, input ready);
  modport sink (input valid, position, angle, target_position, target_down,
                tick_valid, tick_count, output ready);
endinterface

interface lret_result_if ();
  logic valid;
  logic ready;
  logic fire;
  logic angle_fired;
  logic position_fired;

  modport source (output valid, fire, angle_fired, position_fired, input ready);
  modport sink (input valid, fire, angle_fired, position_fired, output ready);
endinterface

interface lret_cfg_if import lret_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lret_cfg_regs.sv -----
module lret_cfg_regs import lret_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lret_cfg_if.sink  cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_tick_spacing   <= '0;
      regs.angle_dead_band    <= '0;
      regs.position_dead_band <= '0;
      regs.ratio_base         <= RATIO_BASE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MIN_TICK_SPACING:   regs.min_tick_spacing   <= cfg.data[SPACING_W-1:0];
        CFG_ANGLE_DEAD_BAND:    regs.angle_dead_band    <= cfg.data[ADB_W-1:0];
        CFG_POSITION_DEAD_BAND: regs.position_dead_band <= cfg.data[PDB_W-1:0];
        CFG_RATIO_BASE:         regs.ratio_base         <= cfg.data[BASE_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

endmodule

// ----- rtl/core/lret_ratio_test.sv -----
module lret_ratio_test import lret_pkg::*; (
  input  logic [PERR_W-1:0] err,
  input  logic [PERR_W-1:0] ref_val,
  input  logic [PDB_W-1:0]  dead_band,
  input  logic [BASE_W-1:0] base,
  output logic              hit
);

  logic [PROD_W-1:0] base_x_err;
  logic [PROD_W-1:0] base_x_ref;
  logic [PROD_W-1:0] err_sc;
  logic [PROD_W-1:0] ref_sc;
  logic              grown;
  logic              shrunk;

  // err/ref >= base or ref/err >= base (base in Q4.12), without the division
  assign base_x_err = {{(PROD_W-BASE_W){1'b0}}, base} * {{(PROD_W-PERR_W){1'b0}}, err};
  assign base_x_ref = {{(PROD_W-BASE_W){1'b0}}, base} * {{(PROD_W-PERR_W){1'b0}}, ref_val};
  assign err_sc     = {{(PROD_W-PERR_W-FRAC_W){1'b0}}, err, {FRAC_W{1'b0}}};
  assign ref_sc     = {{(PROD_W-PERR_W-FRAC_W){1'b0}}, ref_val, {FRAC_W{1'b0}}};

  assign grown  = err_sc >= base_x_ref;
  assign shrunk = ref_sc >= base_x_err;

  assign hit = (err > {{(PERR_W-PDB_W){1'b0}}, dead_band}) && (ref_val != '0)
               && (grown || shrunk);

endmodule

// ----- rtl/core/log_ratio_event_trigger_core.sv -----
// Logarithmic send-on-delta trigger for a cart-pole sample stream. Each accepted
// sample gives exactly one result (fire, angle_fired, position_fired), in order.
// An axis fires when its error is above its dead band and has grown or shrunk by
// at least ratio_base (Q4.12) against the axis reference; a firing updates the
// reference and, with a tick present, the tick spacing throttle. One sample is
// taken every cycle unless result back-pressure stalls it; a sample passes the input
// register, then the result register. The rate is set by the single evaluate
// stage, where the four 16x17 cross products, the throttle compare and the
// reference write-back all close. Configuration writes are taken every cycle and
// should be made only while no sample is in flight.
module log_ratio_event_trigger_core import lret_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lret_sample_if.sink   sample,
  lret_cfg_if.sink      cfg,
  lret_result_if.source result
);

  cfg_t regs;

  lret_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  logic                       s_valid;
  logic signed [SAMPLE_W-1:0] s_position;
  logic signed [SAMPLE_W-1:0] s_angle;
  logic signed [SAMPLE_W-1:0] s_target_position;
  logic                       s_target_down;
  logic                       s_tick_valid;
  logic [TICK_BITS-1:0]       s_tick;

  // state
  logic [AERR_W-1:0]    angle_reference;
  logic [PERR_W-1:0]    position_reference;
  logic [TICK_BITS-1:0] last_fire_tick;
  logic                 last_tick_known;

  logic advance;
  logic step;

  assign advance      = !result.valid || result.ready;
  assign step         = s_valid && advance;
  assign sample.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s_position        <= sample.position;
      s_angle           <= sample.angle;
      s_target_position <= sample.target_position;
      s_target_down     <= sample.target_down;
      s_tick_valid      <= sample.tick_valid;
      s_tick            <= sample.tick_count[TICK_BITS-1:0];
    end
  end

  // throttle: a tick behind the last firing blocks too
  logic [TICK_BITS:0]  tick_diff;
  logic [TCMP_W-1:0]   diff_ext;
  logic [TCMP_W-1:0]   spacing_ext;
  logic                throttle_on;
  logic                blocked;

  assign tick_diff   = {1'b0, s_tick} - {1'b0, last_fire_tick};
  assign diff_ext    = TCMP_W'(tick_diff[TICK_BITS-1:0]);
  assign spacing_ext = TCMP_W'(regs.min_tick_spacing);
  assign throttle_on = (regs.min_tick_spacing != '0) && s_tick_valid && last_tick_known;
  assign blocked     = throttle_on && (tick_diff[TICK_BITS] || (diff_ext < spacing_ext));

  // angle error
  logic [SAMPLE_W:0] ang_ext;
  logic [SAMPLE_W:0] ang_abs;
  logic [SAMPLE_W:0] ang_from_pi;
  logic [AERR_W-1:0] aerr;

  assign ang_ext     = {s_angle[SAMPLE_W-1], s_angle};
  assign ang_abs     = s_angle[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - ang_ext) : ang_ext;
  assign ang_from_pi = PI_LSB - ang_abs;

  always_comb begin
    if (s_target_down) begin
      aerr = (ang_abs > PI_LSB) ? '0 : ang_from_pi[AERR_W-1:0];
    end else begin
      aerr = (ang_abs > {2'b00, ANGLE_ERR_MAX}) ? ANGLE_ERR_MAX : ang_abs[AERR_W-1:0];
    end
  end

  // position error
  logic [PERR_W-1:0] pdiff;
  logic [PERR_W-1:0] perr;

  assign pdiff = {s_position[SAMPLE_W-1], s_position}
               - {s_target_position[SAMPLE_W-1], s_target_position};
  assign perr  = pdiff[PERR_W-1] ? (PERR_W'(0) - pdiff) : pdiff;

  logic a_hit;
  logic p_hit;
  logic afire;
  logic pfire;

  lret_ratio_test u_angle_test (
    .err       ({{(PERR_W-AERR_W){1'b0}}, aerr}),
    .ref_val   ({{(PERR_W-AERR_W){1'b0}}, angle_reference}),
    .dead_band ({{(PDB_W-ADB_W){1'b0}}, regs.angle_dead_band}),
    .base      (regs.ratio_base),
    .hit       (a_hit)
  );

  lret_ratio_test u_position_test (
    .err       (perr),
    .ref_val   (position_reference),
    .dead_band (regs.position_dead_band),
    .base      (regs.ratio_base),
    .hit       (p_hit)
  );

  assign afire = !blocked && a_hit;
  assign pfire = !blocked && p_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reference    <= ANGLE_REF_RESET;
      position_reference <= POS_REF_RESET;
      last_fire_tick     <= '0;
      last_tick_known    <= 1'b0;
    end else if (step) begin
      if (afire) begin
        angle_reference <= aerr;
      end
      if (pfire) begin
        position_reference <= perr;
      end
      if ((afire || pfire) && s_tick_valid) begin
        last_fire_tick  <= s_tick;
        last_tick_known <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.fire           <= afire || pfire;
      result.angle_fired    <= afire;
      result.position_fired <= pfire;
    end
  end

endmodule

// ----- rtl/core/lret_checker.sv -----
`include "log_ratio_event_trigger_core_assert.svh"

module lret_checker (
  input logic clk,
  input logic rst,
  input logic sample_ready,
  input logic result_valid,
  input logic result_ready,
  input logic fire,
  input logic angle_fired,
  input logic position_fired
);

  logic [2:0] flags;

  assign flags = {fire, angle_fired, position_fired};

  // fire is exactly the OR of the axis flags
  `LRET_ASSERT(a_fire_flags, clk, rst, result_valid |-> (fire == (angle_fired || position_fired)))

  // an empty result register never holds back a request
  `LRET_ASSERT(a_ready_when_empty, clk, rst, !result_valid |-> sample_ready)

  `LRET_ASSERT_NORST(a_reset_empty, clk, $past(rst) |-> !result_valid)

  `LRET_ASSERT(a_result_held, clk, rst, (result_valid && !result_ready) |=> result_valid)

  `LRET_ASSERT(a_result_stable, clk, rst, (result_valid && !result_ready) |=> $stable(flags))

endmodule

bind log_ratio_event_trigger_core lret_checker u_lret_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_ready   (sample.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .fire           (result.fire),
  .angle_fired    (result.angle_fired),
  .position_fired (result.position_fired)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb import lret_pkg::*; ();

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] position;
    logic signed [SAMPLE_W-1:0] angle;
    logic signed [SAMPLE_W-1:0] target_position;
    logic                       target_down;
    logic                       tick_valid;
    logic [TICK_COUNT_W-1:0]    tick_count;
  } sample_t;

  typedef struct packed {
    logic fire;
    logic angle_fired;
    logic position_fired;
  } verdict_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] spacing;
    logic [CFG_DATA_W-1:0] angle_band;
    logic [CFG_DATA_W-1:0] position_band;
    logic [CFG_DATA_W-1:0] base;
  } reg_set_t;

  localparam int NUM_REGS        = 4;
  localparam int NUM_PHASES      = 9;
  localparam int PHASE_ITEMS     = 150;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ANGLE_FULL      = 32768;
  localparam int TICK_TOP        = 32'h7fff_ffff;

  // Trigger predictor plus the queue of verdicts still owed by the block.
  class trigger_scoreboard;
    cfg_t                    regs;
    logic [AERR_W-1:0]       angle_anchor;
    logic [PERR_W-1:0]       position_anchor;
    logic [TICK_COUNT_W-1:0] last_tick;
    bit                      tick_known;
    verdict_t                due_verdicts[$];
    int unsigned             n_fail;

    function new();
      regs            = '0;
      regs.ratio_base = RATIO_BASE_RESET;
      angle_anchor    = ANGLE_REF_RESET;
      position_anchor = POS_REF_RESET;
      last_tick       = '0;
      tick_known      = 1'b0;
      n_fail          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_MIN_TICK_SPACING:   regs.min_tick_spacing   = data[SPACING_W-1:0];
        CFG_ANGLE_DEAD_BAND:    regs.angle_dead_band    = data[ADB_W-1:0];
        CFG_POSITION_DEAD_BAND: regs.position_dead_band = data[PDB_W-1:0];
        CFG_RATIO_BASE:         regs.ratio_base         = data[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    // Grown or shrunk by the base, cross multiplied
    function bit ratio_hit(longint err, longint anchor);
      longint one_q, base;
      one_q = longint'(1) << FRAC_W;
      base  = longint'(regs.ratio_base);
      if (anchor == 0) return 1'b0;
      return (err * one_q >= base * anchor) || (anchor * one_q >= base * err);
    endfunction

    function void note_sample(sample_t s);
      int                      ang, aabs, aerr, pdiff, perr;
      longint                  gap;
      bit                      afire, pfire;
      verdict_t                v;
      logic [TICK_COUNT_W-1:0] tick;
      v    = '0;
      tick = '0;
      tick[TICK_BITS-1:0] = s.tick_count[TICK_BITS-1:0];
      if (regs.min_tick_spacing != 0 && s.tick_valid && tick_known) begin
        gap = longint'(tick) - longint'(last_tick);
        if (gap < longint'(regs.min_tick_spacing)) begin
          due_verdicts.push_back(v);
          return;
        end
      end
      ang  = $signed(s.angle);
      aabs = (ang < 0) ? -ang : ang;
      aerr = s.target_down ? int'(PI_LSB) - aabs : aabs;
      if (aerr < 0) aerr = 0;
      if (aerr > int'(ANGLE_ERR_MAX)) aerr = int'(ANGLE_ERR_MAX);
      pdiff = int'($signed(s.position)) - int'($signed(s.target_position));
      perr  = (pdiff < 0) ? -pdiff : pdiff;

      afire = (aerr > int'(regs.angle_dead_band)) && ratio_hit(aerr, angle_anchor);
      pfire = (perr > int'(regs.position_dead_band)) && ratio_hit(perr, position_anchor);
      if (afire) angle_anchor = aerr[AERR_W-1:0];
      if (pfire) position_anchor = perr[PERR_W-1:0];
      if (afire || pfire) begin
        if (s.tick_valid) begin
          last_tick  = tick;
          tick_known = 1'b1;
        end
        v.fire           = 1'b1;
        v.angle_fired    = afire;
        v.position_fired = pfire;
      end
      due_verdicts.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        $error("result with no sample outstanding: fire %0b", got.fire);
        n_fail++;
        return;
      end
      want = due_verdicts.pop_front();
      if (got.fire !== want.fire) begin
        $error("fire: expected %0b, got %0b", want.fire, got.fire);
        n_fail++;
      end
      if (got.angle_fired !== want.angle_fired) begin
        $error("angle_fired: expected %0b, got %0b", want.angle_fired, got.angle_fired);
        n_fail++;
      end
      if (got.position_fired !== want.position_fired) begin
        $error("position_fired: expected %0b, got %0b",
               want.position_fired, got.position_fired);
        n_fail++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lret_sample_if smp_if ();
  lret_result_if res_if ();
  lret_cfg_if    cfg_if ();

  log_ratio_event_trigger_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_if),
    .cfg    (cfg_if),
    .result (res_if)
  );

  trigger_scoreboard sb = new();

  int                      src_idle_pct;
  int                      sink_idle_pct;
  logic [TICK_COUNT_W-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: random back-pressure, checked at the rising edge
  initial begin
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_verdict('{res_if.fire, res_if.angle_fired, res_if.position_fired});
  end

  // Entered and left at a falling edge; valid is left high for the next request.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk);
    end
    smp_if.valid           <= 1'b1;
    smp_if.position        <= s.position;
    smp_if.angle           <= s.angle;
    smp_if.target_position <= s.target_position;
    smp_if.target_down     <= s.target_down;
    smp_if.tick_valid      <= s.tick_valid;
    smp_if.tick_count      <= s.tick_count;
    do @(posedge clk); while (!smp_if.ready);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.due_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sample_t mk(int pos, int ang, int tpos, bit down, bit tv, int tick);
    sample_t s;
    s.position        = 16'(pos);
    s.angle           = 16'(ang);
    s.target_position = 16'(tpos);
    s.target_down     = down;
    s.tick_valid      = tv;
    s.tick_count      = TICK_COUNT_W'(tick);
    return s;
  endfunction

  // Magnitudes spread over octaves so the ratio test both hits and misses
  function automatic int octave_mag(int top_bit);
    int m;
    m = 1 << $urandom_range(0, top_bit);
    return m + int'($urandom_range(0, m / 2));
  endfunction

  function automatic sample_t random_sample();
    int  ang, tpos, diff;
    bit  tv;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: tick_now = TICK_COUNT_W'(tick_now + $urandom_range(0, 24));
      7:                   tick_now = TICK_COUNT_W'(tick_now - $urandom_range(1, 50));
      8:                   tick_now = TICK_COUNT_W'($urandom());
      default:             tick_now = TICK_COUNT_W'(TICK_TOP - int'($urandom_range(0, 30)));
    endcase
    tv = ($urandom_range(0, 9) < 8);

    case ($urandom_range(0, 5))
      0: ang = int'($urandom_range(0, 128)) - 64;
      1: begin
        ang = int'(PI_LSB) - int'($urandom_range(0, 64));
        if ($urandom_range(0, 1)) ang = -ang;
      end
      2: ang = int'($urandom_range(0, 2 * int'(PI_LSB))) - int'(PI_LSB);
      3: ang = int'($urandom_range(0, 65535)) - ANGLE_FULL;
      4: case ($urandom_range(0, 4))
           0: ang = -ANGLE_FULL;
           1: ang = ANGLE_FULL - 1;
           2: ang = int'(PI_LSB);
           3: ang = -int'(PI_LSB);
           default: ang = 0;
         endcase
      default: begin
        ang = octave_mag(13);
        if ($urandom_range(0, 1)) ang = -ang;
      end
    endcase

    tpos = int'($urandom_range(0, 65535)) - ANGLE_FULL;
    case ($urandom_range(0, 3))
      0: diff = int'($urandom_range(0, 65535)) - ANGLE_FULL;
      1: diff = int'($urandom_range(0, 8)) - 4;
      default: begin
        diff = octave_mag(14);
        if ($urandom_range(0, 1)) diff = -diff;
      end
    endcase
    return mk(tpos + diff, ang, tpos, 1'($urandom_range(0, 1)), tv, int'(tick_now));
  endfunction

  function automatic reg_set_t phase_setting(int p);
    reg_set_t rs;
    case (p)
      0: rs = '{16'd0, 16'd0, 16'd0, 16'd8192};
      1: rs = '{16'd10, 16'd100, 16'd200, 16'd4096};
      2: rs = '{16'hffff, 16'd16384, 16'hffff, 16'hffff};
      3: rs = '{16'd1, 16'd0, 16'd0, 16'd0};
      4: rs = '{16'($urandom_range(2, 40)), 16'($urandom_range(0, 16384)),
                16'($urandom_range(0, 2000)), 16'd2048};
      5: rs = '{16'd3, 16'hffff, 16'd0, 16'd6144};
      6: rs = '{16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
      7: rs = '{16'd20, 16'd50, 16'd50, 16'd12288};
      default: rs = '{16'd0, 16'd0, 16'd0, 16'd8192};
    endcase
    return rs;
  endfunction

  initial begin
    sample_t  directed[$];
    reg_set_t rs;

    rst                    = 1'b1;
    src_idle_pct           = 0;
    sink_idle_pct          = 0;
    tick_now               = '0;
    smp_if.valid           = 1'b0;
    smp_if.position        = '0;
    smp_if.angle           = '0;
    smp_if.target_position = '0;
    smp_if.target_down     = 1'b0;
    smp_if.tick_valid      = 1'b0;
    smp_if.tick_count      = '0;
    res_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(CFG_MIN_TICK_SPACING, 16'd10);

    // Zero errors, a ratio just short and just at the base, angle saturation,
    // beyond-pi clamp, throttle blocking / going backwards / bypass, position extremes
    directed.push_back(mk(0, 0, 0, 0, 0, 0));
    directed.push_back(mk(0, 1, 0, 0, 0, 0));
    directed.push_back(mk(0, 2, 0, 0, 0, 0));
    directed.push_back(mk(0, -ANGLE_FULL, 0, 0, 1, 100));
    directed.push_back(mk(0, ANGLE_FULL - 1, 0, 1, 1, 101));
    directed.push_back(mk(0, 0, 0, 1, 1, 50));
    directed.push_back(mk(0, 0, 0, 1, 0, 0));
    directed.push_back(mk(ANGLE_FULL - 1, int'(PI_LSB), -ANGLE_FULL, 1, 1, 110));
    directed.push_back(mk(-ANGLE_FULL, -int'(PI_LSB), ANGLE_FULL - 1, 0, 1, 111));
    directed.push_back(mk(1, int'(PI_LSB), 0, 0, 1, TICK_TOP));
    directed.push_back(mk(0, 3, 0, 0, 1, 0));
    directed.push_back(mk(-1, -1, 0, 1, 0, TICK_TOP));
    directed.push_back(mk(4, -20000, 0, 1, 1, TICK_TOP));
    directed.push_back(mk(200, 1, 0, 0, 0, 0));
    directed.push_back(mk(-ANGLE_FULL, ANGLE_FULL - 1, -ANGLE_FULL, 0, 0, 0));
    directed.push_back(mk(ANGLE_FULL - 1, 0, ANGLE_FULL - 1, 1, 0, 0));
    foreach (directed[i]) send_sample(directed[i]);
    smp_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      rs = phase_setting(p);
      write_reg(CFG_MIN_TICK_SPACING, rs.spacing);
      write_reg(CFG_ANGLE_DEAD_BAND, rs.angle_band);
      write_reg(CFG_POSITION_DEAD_BAND, rs.position_band);
      write_reg(CFG_RATIO_BASE, rs.base);
      // indices past the register list must be ignored
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), 16'($urandom()));

      if (p < 3) begin
        src_idle_pct  = 33;
        sink_idle_pct = 87;
      end else if (p < 6) begin
        src_idle_pct  = 87;
        sink_idle_pct = 33;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          // hold requests back until the block has emptied
          smp_if.valid <= 1'b0;
          drain();
        end
        send_sample(random_sample());
      end
      smp_if.valid <= 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.n_fail == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lret_pkg.sv
rtl/core/lret_ifs.sv
rtl/core/lret_cfg_regs.sv
rtl/core/lret_ratio_test.sv
rtl/core/log_ratio_event_trigger_core.sv
rtl/core/lret_checker.sv
tb/sv/tb.sv
